// ===== sv/cip_pkg.sv =====
// Shared types and constants for the index parser core.
// No dependencies; imported by every module of the block.
package cip_pkg;

   // Depth of the queue between the byte classifier and the parser.
   localparam int CIP_QUEUE_DEPTH = 4;

   localparam int LEN_W    = 32;
   localparam int STATUS_W = 4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OBJECT  = 4'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 4'd1;
   localparam logic [STATUS_W-1:0] ST_TRUNC   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_OFFSIZE = 4'd3;
   localparam logic [STATUS_W-1:0] ST_OVERRUN = 4'd4;
   localparam logic [STATUS_W-1:0] ST_ZERO    = 4'd5;
   localparam logic [STATUS_W-1:0] ST_FIRST   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_BOUNDS  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_ORDER   = 4'd8;

   // One classified byte, as queued from front to back.
   typedef struct packed {
      logic             start;     // first byte of a region
      logic [7:0]       data;
      logic [LEN_W-1:0] length;    // region length, meaningful with start
      logic             short4;    // region too short for the count
      logic             short5;    // region too short for the offset size byte
   } cip_item_type;

endpackage

// ===== sv/cip_front.sv =====
// Input stage: registers a request word and classifies the region length.
// Depends on cip_pkg.
module cip_front
   import cip_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic             in_start,
   input  logic [7:0]       in_data,
   input  logic [LEN_W-1:0] in_length,
   output logic             out_valid,
   input  logic             out_ready,
   output cip_item_type     out_item
);

   logic         vld_ff, vld_in;
   cip_item_type item_ff, item_in;
   logic         take;

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      item_in.start  = in_start;
      item_in.data   = in_data;
      item_in.length = in_length;
      item_in.short4 = in_length < LEN_W'(4);
      item_in.short5 = in_length < LEN_W'(5);
      vld_in = take || (vld_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

// ===== sv/cip_queue.sv =====
// Small FIFO of classified bytes between the front stage and the parser.
// Depends on cip_pkg.
module cip_queue
   import cip_pkg::*;
#(
   parameter int DEPTH = CIP_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         push_ready,
   input  cip_item_type push_item,
   output logic         pop_valid,
   input  logic         pop,
   output cip_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cip_item_type     slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/cip_back.sv =====
// Parser: walks count, offset size and offset array, checks each field,
// and holds the result word in an output register. Depends on cip_pkg.
module cip_back
   import cip_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_pop,
   input  cip_item_type        in_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LEN_W-1:0]    rsp_offset,
   output logic [LEN_W-1:0]    rsp_length,
   output logic [LEN_W-1:0]    rsp_count,
   output logic                rsp_last
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_COUNT   = 2'd1;
   localparam logic [1:0] PH_OFFSIZE = 2'd2;
   localparam logic [1:0] PH_OFFSETS = 2'd3;

   logic [1:0]       phase_ff,    phase_in;
   logic [LEN_W-1:0] len_ff,      len_in;
   logic             lt5_ff,      lt5_in;
   logic [LEN_W-1:0] count_ff,    count_in;
   logic [LEN_W:0]   cnt_p1_ff,   cnt_p1_in;
   logic [2:0]       obytes_ff,   obytes_in;
   logic [1:0]       bif_ff,      bif_in;
   logic [LEN_W-1:0] acc_ff,      acc_in;
   logic [LEN_W-1:0] entry_ff,    entry_in;
   logic [LEN_W-1:0] ds_m1_ff,    ds_m1_in;    // data start minus one
   logic [LEN_W-1:0] prev_end_ff, prev_end_in;
   logic [LEN_W-1:0] prev_acc_ff, prev_acc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff,    status_in;
   logic [LEN_W-1:0]    offset_ff,    offset_in;
   logic [LEN_W-1:0]    length_ff,    length_in;
   logic [LEN_W-1:0]    rcount_ff,    rcount_in;
   logic                last_ff,      last_in;

   logic             step;
   logic             emit;
   logic [7:0]       b;
   logic [1:0]       bif_next;
   logic [LEN_W-1:0] shifted_count;
   logic [LEN_W-1:0] shifted_acc;
   logic [LEN_W+3:0] ds_m1_wide;
   logic [LEN_W:0]   abs_end;

   assign step   = in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_pop = step;
   assign b      = in_item.data;

   assign bif_next      = bif_ff + 2'd1;
   assign shifted_count = {count_ff[LEN_W-9:0], b};
   assign shifted_acc   = {acc_ff[LEN_W-9:0], b};
   // 4 + (count + 1) * offset size; small multiplier, at most 4
   assign ds_m1_wide    = (LEN_W+4)'(4) + (LEN_W+4)'(cnt_p1_ff) * (LEN_W+4)'(b[2:0]);
   assign abs_end       = {1'b0, ds_m1_ff} + {1'b0, shifted_acc};

   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      lt5_in      = lt5_ff;
      count_in    = count_ff;
      cnt_p1_in   = cnt_p1_ff;
      obytes_in   = obytes_ff;
      bif_in      = bif_ff;
      acc_in      = acc_ff;
      entry_in    = entry_ff;
      ds_m1_in    = ds_m1_ff;
      prev_end_in = prev_end_ff;
      prev_acc_in = prev_acc_ff;
      emit        = 1'b0;
      status_in   = ST_OBJECT;
      offset_in   = '0;
      length_in   = '0;
      last_in     = 1'b1;

      if (step) begin
         if (in_item.start) begin
            len_in   = in_item.length;
            lt5_in   = in_item.short5;
            count_in = '0;
            if (in_item.short4) begin
               emit      = 1'b1;
               status_in = ST_TRUNC;
               phase_in  = PH_IDLE;
            end else begin
               count_in = LEN_W'(b);
               bif_in   = 2'd1;
               phase_in = PH_COUNT;
            end
         end else begin
            case (phase_ff)
               PH_COUNT: begin
                  count_in = shifted_count;
                  bif_in   = bif_next;
                  if (bif_next == 2'd0) begin
                     cnt_p1_in = {1'b0, shifted_count} + 1'b1;
                     if (shifted_count == '0) begin
                        emit      = 1'b1;
                        status_in = ST_EMPTY;
                        phase_in  = PH_IDLE;
                     end else if (lt5_ff) begin
                        emit      = 1'b1;
                        status_in = ST_TRUNC;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_OFFSIZE;
                     end
                  end
               end
               PH_OFFSIZE: begin
                  if (b < 8'd1 || b > 8'd4) begin
                     emit      = 1'b1;
                     status_in = ST_OFFSIZE;
                     phase_in  = PH_IDLE;
                  end else if (ds_m1_wide >= (LEN_W+4)'(len_ff)) begin
                     emit      = 1'b1;
                     status_in = ST_OVERRUN;
                     phase_in  = PH_IDLE;
                  end else begin
                     obytes_in = b[2:0];
                     ds_m1_in  = ds_m1_wide[LEN_W-1:0];
                     bif_in    = 2'd0;
                     acc_in    = '0;
                     entry_in  = '0;
                     phase_in  = PH_OFFSETS;
                  end
               end
               PH_OFFSETS: begin
                  acc_in = shifted_acc;
                  bif_in = bif_next;
                  // offset size 4 completes when the byte counter wraps to zero
                  if (bif_next == obytes_ff[1:0]) begin
                     bif_in = 2'd0;
                     acc_in = '0;
                     if (shifted_acc == '0) begin
                        emit      = 1'b1;
                        status_in = ST_ZERO;
                        phase_in  = PH_IDLE;
                     end else if (entry_ff == '0 && shifted_acc != LEN_W'(1)) begin
                        emit      = 1'b1;
                        status_in = ST_FIRST;
                        phase_in  = PH_IDLE;
                     end else if (abs_end > {1'b0, len_ff}) begin
                        emit      = 1'b1;
                        status_in = ST_BOUNDS;
                        phase_in  = PH_IDLE;
                     end else if (entry_ff == '0) begin
                        prev_end_in = abs_end[LEN_W-1:0];
                        prev_acc_in = shifted_acc;
                        entry_in    = LEN_W'(1);
                     end else if (shifted_acc < prev_acc_ff) begin
                        // same base on both ends, so offsets order like ends
                        emit      = 1'b1;
                        status_in = ST_ORDER;
                        phase_in  = PH_IDLE;
                     end else begin
                        emit        = 1'b1;
                        status_in   = ST_OBJECT;
                        offset_in   = prev_end_ff;
                        length_in   = shifted_acc - prev_acc_ff;
                        prev_end_in = abs_end[LEN_W-1:0];
                        prev_acc_in = shifted_acc;
                        if (entry_ff >= count_ff) begin
                           last_in  = 1'b1;
                           phase_in = PH_IDLE;
                        end else begin
                           last_in  = 1'b0;
                           entry_in = entry_ff + 1'b1;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end

      rcount_in = count_in;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      lt5_ff      <= lt5_in;
      count_ff    <= count_in;
      cnt_p1_ff   <= cnt_p1_in;
      obytes_ff   <= obytes_in;
      bif_ff      <= bif_in;
      acc_ff      <= acc_in;
      entry_ff    <= entry_in;
      ds_m1_ff    <= ds_m1_in;
      prev_end_ff <= prev_end_in;
      prev_acc_ff <= prev_acc_in;
      if (emit) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
         length_ff <= length_in;
         rcount_ff <= rcount_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_offset = offset_ff;
   assign rsp_length = length_ff;
   assign rsp_count  = rcount_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== sv/cff2_index_parser_core.sv =====
// Index region parser core: top level.
// Depends on cip_pkg, cip_front, cip_queue and cip_back.
//  - req channel carries one region byte per word. req_tuser high marks
//    the first byte of a region and samples the region length; the parser
//    restarts on it at once, even in the middle of a region.
//  - The region holds a 32-bit big-endian object count, an offset size
//    byte (1..4) and count+1 big-endian offsets. For each offset after the
//    first, one rsp word gives the object's start and length in the region.
//  - rsp_tuser carries the status (object, empty done, or an error code);
//    rsp_tlast marks the final word of a region. Parsing stops at the
//    first error; later bytes are dropped until the next start byte.
//  - A byte yields zero or one result word.
//  - Throughput: one byte per cycle, sustained while the result register is
//    free or rsp_tready is high; each parser step does shift, add and compares.
//  - From req acceptance to rsp_tvalid a byte passes the input register,
//    a queue slot and the parser step into the output register.
//  - When rsp_tready is low the parser holds its result and stops popping;
//    the queue fills, then req_tready drops.
//  - Reset (synchronous, active high) empties the queue and output register
//    and returns the parser to idle, waiting for a start byte.
module cff2_index_parser_core
   import cip_pkg::*;
#(
   parameter int QUEUE_DEPTH = CIP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] region_length
   input  logic        req_tuser,   // [0] start_req
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] object_offset, [63:32] object_length,
                                    // [95:64] object_count
   output logic [3:0]  rsp_tuser,   // [3:0] status
   output logic        rsp_tlast
);

   cip_item_type front_item;
   cip_item_type queue_item;
   logic         front_valid;
   logic         queue_ready;
   logic         queue_valid;
   logic         back_pop;

   logic [LEN_W-1:0] rsp_offset;
   logic [LEN_W-1:0] rsp_length;
   logic [LEN_W-1:0] rsp_count;

   // Front: register and classify each incoming byte.
   cip_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_start  (req_tuser),
      .in_data   (req_tdata[7:0]),
      .in_length (req_tdata[39:8]),
      .out_valid (front_valid),
      .out_ready (queue_ready),
      .out_item  (front_item)
   );

   // Queue decoupling the front from the parser.
   cip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_ready (queue_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop        (back_pop),
      .pop_item   (queue_item)
   );

   // Back: parser state machine and result register.
   cip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_pop     (back_pop),
      .in_item    (queue_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_offset (rsp_offset),
      .rsp_length (rsp_length),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {rsp_count, rsp_length, rsp_offset};

endmodule
